### sv/asmd_pkg.sv
// Shared constants and stage schedule for the arc to segment distance pipeline.
`timescale 1ns / 1ps

package asmd_pkg;

    // Squared segment length must exceed this for the perpendicular candidates.
    localparam logic [31:0] DEGEN_LIMIT = 32'd4294;
    localparam logic [31:0] DIST_SAT    = 32'hFFFF_FFFF;

    // Fixed widths of the radius and direction datapath
    localparam int KM_W  = 24;   // curvature magnitude
    localparam int RAD_W = 33;   // radius in LSBs
    localparam int NRM_W = 31;   // normalized direction components
    localparam int LEN_W = 48;   // direction length, 16 fraction bits
    localparam int OQ_W  = 34;   // offset quotient

    // Stage schedule, in register stages after the input stage
    localparam int S_MUL        = 1;
    localparam int S_CLS        = 2;
    localparam int S_SQ         = 3;
    localparam int S_TDIV_FIRST = 3;
    localparam int S_TDIV_LAST  = 34;
    localparam int S_RDIV_FIRST = 3;
    localparam int S_RDIV_LAST  = 35;
    localparam int S_LEN_FIRST  = 4;
    localparam int S_LEN_LAST   = 51;
    localparam int S_OPR        = 52;
    localparam int S_OINIT      = 53;
    localparam int S_ODIV_FIRST = 54;
    localparam int S_ODIV_LAST  = 87;
    localparam int S_RND        = 88;
    localparam int S_BPR        = 89;
    localparam int S_BSUM       = 90;
    localparam int S_SEL        = 91;
    localparam int S_FSQ_FIRST  = 92;

endpackage

### sv/arc_segment_max_distance.sv
// Arc to segment maximum distance: fully pipelined geometry query engine.
// Usage:
//   Query beats arrive on s_tvalid/s_tready/s_tdata, one segment, arc endpoints,
//   center and curvature per beat. Each beat yields one result beat on
//   m_tvalid/m_tready/m_tdata: the largest nearest-point distance and the
//   segment and arc points that give it.
// Datapath: the length square root takes 48 steps, the offset divider 34 and the
//   distance root COORD_WIDTH+1 steps, each one digit per stage.
// Throughput: one beat per cycle. Every stage holds its own item with a valid
//   bit, so a new query enters each cycle the output side is not stalled.
// Stall: when m_tvalid is high and m_tready low, the whole pipeline holds and
//   s_tready drops; nothing is lost or repeated. Bubbles travel as empty stages.
// Reset: rst_n clears all valid bits; no clearing pass is needed.
`timescale 1ns / 1ps

module arc_segment_max_distance #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // seg_start_x, seg_start_y, seg_end_x, seg_end_y, arc_start_x, arc_start_y,
    // arc_end_x, arc_end_y, center_x, center_y, curvature (24 bits), zero pad
    input  logic [((10*COORD_WIDTH+24+7)/8)*8-1:0]  s_tdata,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // max_distance (32 bits), seg_point_x, seg_point_y, arc_point_x,
    // arc_point_y, zero pad
    output logic [((32+4*COORD_WIDTH+7)/8)*8-1:0]   m_tdata
);

    localparam int CW     = COORD_WIDTH;
    localparam int DW     = CW + 1;
    localparam int PW     = 2 * CW + 2;
    localparam int SW     = ((CW > 36) ? CW : 36) + 1;
    localparam int DR     = CW + 1;
    localparam int DXW    = (DR > 33) ? DR : 33;
    localparam int OUT_TW = ((32 + 4 * CW + 7) / 8) * 8;
    localparam int S_OUT  = asmd_pkg::S_FSQ_FIRST + DR;
    localparam int NST    = S_OUT + 1;

    typedef struct packed {
        logic signed [CW-1:0]               p0x, p0y, p1x, p1y, q0x, q0y, q1x, q1y, cx, cy;
        logic signed [23:0]                 k;
        logic signed [DW-1:0]               dx, dy;
        logic [2:0][DW-1:0]                 ex, ey;
        logic [PW-1:0]                      den;
        logic [2:0][PW-1:0]                 nm;
        logic [CW-1:0]                      ux, uy;
        logic [asmd_pkg::KM_W-1:0]          km;
        logic [2:0]                         ins, far;
        logic                               perp;
        logic [2:0][PW-1:0]                 tr;
        logic [2:0][31:0]                   tq;
        logic [asmd_pkg::RAD_W-1:0]         rnum, rad;
        logic [asmd_pkg::KM_W-1:0]          rrem;
        logic [asmd_pkg::NRM_W-1:0]         nx, ny;
        logic [95:0]                        lsrc;
        logic [asmd_pkg::LEN_W+1:0]         lrem;
        logic [asmd_pkg::LEN_W-1:0]         len;
        logic [63:0]                        prx, pry;
        logic [5:0][CW+31:0]                sp;
        logic [asmd_pkg::OQ_W-1:0]          olx, oly, oqx, oqy;
        logic [asmd_pkg::LEN_W-1:0]         orx, ory;
        logic [2:0][CW-1:0]                 npx, npy;
        logic signed [CW-1:0]               ax, ay, bx, by;
        logic [7:0][PW-1:0]                 bp, dp;
        logic [3:0][PW-1:0]                 d2;
        logic [3:0]                         ok;
        logic [PW-1:0]                      bd2;
        logic [CW-1:0]                      bpx, bpy, bqx, bqy;
        logic [PW-1:0]                      fsrc;
        logic [DR+1:0]                      frem;
        logic [DR-1:0]                      fres;
        logic [31:0]                        max_dist;
    } pipe_t;

    function automatic logic signed [PW-1:0] smul(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
        smul = a * b;
    endfunction

    function automatic logic signed [CW-1:0] clampc(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] hi;
        logic signed [SW-1:0] lo;
        hi = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
        lo = ~hi;
        if (v > hi)
        begin
            clampc = hi[CW-1:0];
        end
        else if (v < lo)
        begin
            clampc = lo[CW-1:0];
        end
        else
        begin
            clampc = v[CW-1:0];
        end
    endfunction

    function automatic pipe_t advance(input pipe_t pin, input int s);
        pipe_t                          p;
        logic signed [PW-1:0]           num, sa, sb;
        logic [PW:0]                    tpre;
        logic [asmd_pkg::KM_W:0]        rpre;
        logic [asmd_pkg::LEN_W+3:0]     lpre, ltry;
        logic [asmd_pkg::LEN_W:0]       opre;
        logic [CW-1:0]                  m;
        logic [CW+30:0]                 wx, wy;
        logic [62:0]                    sq;
        logic [CW-1:0]                  v;
        logic [CW+31:0]                 rs;
        logic signed [DW-1:0]           t1, t2, t3, t4;
        logic signed [SW-1:0]           ox, oy;
        logic [asmd_pkg::OQ_W:0]        om;
        logic [DR+3:0]                  fpre, ftry;
        logic [DXW-1:0]                 dext;
        int                             h;
        p = pin;

        if (s == asmd_pkg::S_MUL)
        begin
            p.den = smul(p.dx, p.dx) + smul(p.dy, p.dy);
            for (int j = 0; j < 3; j++)
            begin
                p.nm[j] = smul(p.ex[j], p.dx) + smul(p.ey[j], p.dy);
            end
            p.ux = p.dx[DW-1] ? CW'(-p.dx) : CW'(p.dx);
            p.uy = p.dy[DW-1] ? CW'(-p.dy) : CW'(p.dy);
            p.km = p.k[23] ? asmd_pkg::KM_W'(-p.k) : asmd_pkg::KM_W'(p.k);
        end

        if (s == asmd_pkg::S_CLS)
        begin
            for (int j = 0; j < 3; j++)
            begin
                num = $signed(p.nm[j]);
                p.ins[j] = (p.den != '0) && !num[PW-1] && (num != '0) && (p.nm[j] < p.den);
                p.far[j] = (p.den != '0) && !num[PW-1] && (num != '0) && (p.nm[j] >= p.den);
                p.tr[j]  = p.nm[j];
                p.tq[j]  = '0;
            end
            p.perp = (p.k != '0) && (p.den > PW'(asmd_pkg::DEGEN_LIMIT)) && p.ins[2];
            p.rnum = {1'b1, 32'b0} + asmd_pkg::RAD_W'(p.km >> 1);
            p.rrem = '0;
            p.rad  = '0;
            // Bring the larger direction component into [2^30, 2^31)
            m = (p.ux > p.uy) ? p.ux : p.uy;
            h = 0;
            for (int b = 0; b < CW; b++)
            begin
                if (m[b])
                begin
                    h = b;
                end
            end
            wx = {31'b0, p.ux};
            wy = {31'b0, p.uy};
            if (h >= 30)
            begin
                p.nx = asmd_pkg::NRM_W'(wx >> (h - 30));
                p.ny = asmd_pkg::NRM_W'(wy >> (h - 30));
            end
            else
            begin
                p.nx = asmd_pkg::NRM_W'(wx << (30 - h));
                p.ny = asmd_pkg::NRM_W'(wy << (30 - h));
            end
        end

        if (s == asmd_pkg::S_SQ)
        begin
            sq     = 63'(p.nx * p.nx) + 63'(p.ny * p.ny);
            p.lsrc = {1'b0, sq, 32'b0};
            p.lrem = '0;
            p.len  = '0;
        end

        if (s >= asmd_pkg::S_TDIV_FIRST && s <= asmd_pkg::S_TDIV_LAST)
        begin
            for (int j = 0; j < 3; j++)
            begin
                tpre = {p.tr[j], 1'b0};
                if (tpre >= {1'b0, p.den})
                begin
                    p.tr[j] = PW'(tpre - {1'b0, p.den});
                    p.tq[j] = {p.tq[j][30:0], 1'b1};
                end
                else
                begin
                    p.tr[j] = tpre[PW-1:0];
                    p.tq[j] = {p.tq[j][30:0], 1'b0};
                end
            end
        end

        if (s >= asmd_pkg::S_RDIV_FIRST && s <= asmd_pkg::S_RDIV_LAST)
        begin
            rpre   = {p.rrem, p.rnum[asmd_pkg::RAD_W-1]};
            p.rnum = {p.rnum[asmd_pkg::RAD_W-2:0], 1'b0};
            if (rpre >= {1'b0, p.km})
            begin
                p.rrem = asmd_pkg::KM_W'(rpre - {1'b0, p.km});
                p.rad  = {p.rad[asmd_pkg::RAD_W-2:0], 1'b1};
            end
            else
            begin
                p.rrem = rpre[asmd_pkg::KM_W-1:0];
                p.rad  = {p.rad[asmd_pkg::RAD_W-2:0], 1'b0};
            end
        end

        if (s >= asmd_pkg::S_LEN_FIRST && s <= asmd_pkg::S_LEN_LAST)
        begin
            lpre   = {p.lrem, p.lsrc[95:94]};
            ltry   = {2'b00, p.len, 2'b01};
            p.lsrc = {p.lsrc[93:0], 2'b00};
            if (lpre >= ltry)
            begin
                p.lrem = (asmd_pkg::LEN_W+2)'(lpre - ltry);
                p.len  = {p.len[asmd_pkg::LEN_W-2:0], 1'b1};
            end
            else
            begin
                p.lrem = lpre[asmd_pkg::LEN_W+1:0];
                p.len  = {p.len[asmd_pkg::LEN_W-2:0], 1'b0};
            end
        end

        if (s == asmd_pkg::S_OPR)
        begin
            p.prx = 64'(p.ny * p.rad);
            p.pry = 64'(p.nx * p.rad);
            for (int j = 0; j < 3; j++)
            begin
                p.sp[2*j]   = (CW+32)'(p.ux * p.tq[j]);
                p.sp[2*j+1] = (CW+32)'(p.uy * p.tq[j]);
            end
        end

        if (s == asmd_pkg::S_OINIT)
        begin
            // Top numerator bits stay below len, so only 34 quotient bits remain
            p.orx = asmd_pkg::LEN_W'(p.prx >> 18);
            p.ory = asmd_pkg::LEN_W'(p.pry >> 18);
            p.olx = {p.prx[17:0], 16'b0};
            p.oly = {p.pry[17:0], 16'b0};
            p.oqx = '0;
            p.oqy = '0;
            for (int j = 0; j < 3; j++)
            begin
                rs = p.sp[2*j] + (CW+32)'(33'h0_8000_0000);
                v  = rs[CW+31:32];
                t1 = p.dx[DW-1] ? (DW'(p.p0x) - $signed({1'b0, v}))
                                : (DW'(p.p0x) + $signed({1'b0, v}));
                rs = p.sp[2*j+1] + (CW+32)'(33'h0_8000_0000);
                v  = rs[CW+31:32];
                t2 = p.dy[DW-1] ? (DW'(p.p0y) - $signed({1'b0, v}))
                                : (DW'(p.p0y) + $signed({1'b0, v}));
                if (p.ins[j])
                begin
                    p.npx[j] = t1[CW-1:0];
                    p.npy[j] = t2[CW-1:0];
                end
                else if (p.far[j])
                begin
                    p.npx[j] = p.p1x;
                    p.npy[j] = p.p1y;
                end
                else
                begin
                    p.npx[j] = p.p0x;
                    p.npy[j] = p.p0y;
                end
            end
        end

        if (s >= asmd_pkg::S_ODIV_FIRST && s <= asmd_pkg::S_ODIV_LAST)
        begin
            opre  = {p.orx, p.olx[asmd_pkg::OQ_W-1]};
            p.olx = {p.olx[asmd_pkg::OQ_W-2:0], 1'b0};
            if (opre >= {1'b0, p.len})
            begin
                p.orx = asmd_pkg::LEN_W'(opre - {1'b0, p.len});
                p.oqx = {p.oqx[asmd_pkg::OQ_W-2:0], 1'b1};
            end
            else
            begin
                p.orx = opre[asmd_pkg::LEN_W-1:0];
                p.oqx = {p.oqx[asmd_pkg::OQ_W-2:0], 1'b0};
            end
            opre  = {p.ory, p.oly[asmd_pkg::OQ_W-1]};
            p.oly = {p.oly[asmd_pkg::OQ_W-2:0], 1'b0};
            if (opre >= {1'b0, p.len})
            begin
                p.ory = asmd_pkg::LEN_W'(opre - {1'b0, p.len});
                p.oqy = {p.oqy[asmd_pkg::OQ_W-2:0], 1'b1};
            end
            else
            begin
                p.ory = opre[asmd_pkg::LEN_W-1:0];
                p.oqy = {p.oqy[asmd_pkg::OQ_W-2:0], 1'b0};
            end
        end

        if (s == asmd_pkg::S_RND)
        begin
            // Round half up on the remainder, then take the sign of the direction
            om = {1'b0, p.oqx} + (asmd_pkg::OQ_W+1)'({p.orx, 1'b0} >= {1'b0, p.len});
            ox = p.dy[DW-1] ? -$signed(SW'(om)) : $signed(SW'(om));
            om = {1'b0, p.oqy} + (asmd_pkg::OQ_W+1)'({p.ory, 1'b0} >= {1'b0, p.len});
            oy = p.dx[DW-1] ? -$signed(SW'(om)) : $signed(SW'(om));
            p.ax = clampc(SW'(p.cx) + ox);
            p.ay = clampc(SW'(p.cy) - oy);
            p.bx = clampc(SW'(p.cx) - ox);
            p.by = clampc(SW'(p.cy) + oy);
        end

        if (s == asmd_pkg::S_BPR)
        begin
            t1 = DW'(p.q1x) - DW'(p.q0x);
            t2 = DW'(p.q1y) - DW'(p.q0y);
            p.bp[0] = smul(t1, DW'(p.ax) - DW'(p.q0x));
            p.bp[1] = smul(t2, DW'(p.ay) - DW'(p.q0y));
            p.bp[2] = smul(t1, DW'(p.ax) - DW'(p.q1x));
            p.bp[3] = smul(t2, DW'(p.ay) - DW'(p.q1y));
            p.bp[4] = smul(t1, DW'(p.bx) - DW'(p.q0x));
            p.bp[5] = smul(t2, DW'(p.by) - DW'(p.q0y));
            p.bp[6] = smul(t1, DW'(p.bx) - DW'(p.q1x));
            p.bp[7] = smul(t2, DW'(p.by) - DW'(p.q1y));
            t1 = DW'($signed(p.npx[0])) - DW'(p.q0x);
            t2 = DW'($signed(p.npy[0])) - DW'(p.q0y);
            p.dp[0] = smul(t1, t1);
            p.dp[1] = smul(t2, t2);
            t1 = DW'($signed(p.npx[1])) - DW'(p.q1x);
            t2 = DW'($signed(p.npy[1])) - DW'(p.q1y);
            p.dp[2] = smul(t1, t1);
            p.dp[3] = smul(t2, t2);
            t3 = DW'($signed(p.npx[2])) - DW'(p.ax);
            t4 = DW'($signed(p.npy[2])) - DW'(p.ay);
            p.dp[4] = smul(t3, t3);
            p.dp[5] = smul(t4, t4);
            t3 = DW'($signed(p.npx[2])) - DW'(p.bx);
            t4 = DW'($signed(p.npy[2])) - DW'(p.by);
            p.dp[6] = smul(t3, t3);
            p.dp[7] = smul(t4, t4);
        end

        if (s == asmd_pkg::S_BSUM)
        begin
            for (int j = 0; j < 4; j++)
            begin
                p.d2[j] = p.dp[2*j] + p.dp[2*j+1];
            end
            sa = $signed(p.bp[0]) + $signed(p.bp[1]);
            sb = $signed(p.bp[2]) + $signed(p.bp[3]);
            p.ok[0] = 1'b1;
            p.ok[1] = 1'b1;
            p.ok[2] = p.perp && !sa[PW-1] && (sa != '0) && sb[PW-1];
            sa = $signed(p.bp[4]) + $signed(p.bp[5]);
            sb = $signed(p.bp[6]) + $signed(p.bp[7]);
            p.ok[3] = p.perp && !sa[PW-1] && (sa != '0) && sb[PW-1];
        end

        if (s == asmd_pkg::S_SEL)
        begin
            // Later candidates win only on a strictly larger distance
            p.bd2 = p.d2[0];
            p.bpx = p.npx[0];
            p.bpy = p.npy[0];
            p.bqx = p.q0x;
            p.bqy = p.q0y;
            if (p.d2[1] > p.bd2)
            begin
                p.bd2 = p.d2[1];
                p.bpx = p.npx[1];
                p.bpy = p.npy[1];
                p.bqx = p.q1x;
                p.bqy = p.q1y;
            end
            if (p.ok[2] && (p.d2[2] > p.bd2))
            begin
                p.bd2 = p.d2[2];
                p.bpx = p.npx[2];
                p.bpy = p.npy[2];
                p.bqx = p.ax;
                p.bqy = p.ay;
            end
            if (p.ok[3] && (p.d2[3] > p.bd2))
            begin
                p.bd2 = p.d2[3];
                p.bpx = p.npx[2];
                p.bpy = p.npy[2];
                p.bqx = p.bx;
                p.bqy = p.by;
            end
            p.fsrc = p.bd2;
            p.frem = '0;
            p.fres = '0;
        end

        if (s >= asmd_pkg::S_FSQ_FIRST && s < S_OUT)
        begin
            fpre   = {p.frem, p.fsrc[PW-1:PW-2]};
            ftry   = {2'b00, p.fres, 2'b01};
            p.fsrc = {p.fsrc[PW-3:0], 2'b00};
            if (fpre >= ftry)
            begin
                p.frem = (DR+2)'(fpre - ftry);
                p.fres = {p.fres[DR-2:0], 1'b1};
            end
            else
            begin
                p.frem = fpre[DR+1:0];
                p.fres = {p.fres[DR-2:0], 1'b0};
            end
        end

        if (s == S_OUT)
        begin
            dext = DXW'(p.fres);
            p.max_dist = (dext > DXW'(asmd_pkg::DIST_SAT)) ? asmd_pkg::DIST_SAT : dext[31:0];
        end

        advance = p;
    endfunction

    pipe_t            st_reg  [NST];
    pipe_t            st_next [NST];
    logic [NST-1:0]   vld_reg;
    logic             en;

    assign en       = !vld_reg[NST-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[NST-1];
    assign m_tdata  = OUT_TW'({st_reg[NST-1].bqy, st_reg[NST-1].bqx,
                               st_reg[NST-1].bpy, st_reg[NST-1].bpx,
                               st_reg[NST-1].max_dist});

    always_comb
    begin
        st_next[0]     = '0;
        st_next[0].p0x = $signed(s_tdata[0*CW +: CW]);
        st_next[0].p0y = $signed(s_tdata[1*CW +: CW]);
        st_next[0].p1x = $signed(s_tdata[2*CW +: CW]);
        st_next[0].p1y = $signed(s_tdata[3*CW +: CW]);
        st_next[0].q0x = $signed(s_tdata[4*CW +: CW]);
        st_next[0].q0y = $signed(s_tdata[5*CW +: CW]);
        st_next[0].q1x = $signed(s_tdata[6*CW +: CW]);
        st_next[0].q1y = $signed(s_tdata[7*CW +: CW]);
        st_next[0].cx  = $signed(s_tdata[8*CW +: CW]);
        st_next[0].cy  = $signed(s_tdata[9*CW +: CW]);
        st_next[0].k   = $signed(s_tdata[10*CW +: 24]);
        st_next[0].dx  = DW'(st_next[0].p1x) - DW'(st_next[0].p0x);
        st_next[0].dy  = DW'(st_next[0].p1y) - DW'(st_next[0].p0y);
        st_next[0].ex[0] = DW'(st_next[0].q0x) - DW'(st_next[0].p0x);
        st_next[0].ey[0] = DW'(st_next[0].q0y) - DW'(st_next[0].p0y);
        st_next[0].ex[1] = DW'(st_next[0].q1x) - DW'(st_next[0].p0x);
        st_next[0].ey[1] = DW'(st_next[0].q1y) - DW'(st_next[0].p0y);
        st_next[0].ex[2] = DW'(st_next[0].cx) - DW'(st_next[0].p0x);
        st_next[0].ey[2] = DW'(st_next[0].cy) - DW'(st_next[0].p0y);
        for (int i = 1; i < NST; i++)
        begin
            st_next[i] = advance(st_reg[i-1], i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
        end
    end

    // Payload advances with the valid bits and holds on a stall
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NST; i++)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

endmodule
